/* rtl/core/akf_pkg.sv */
// ----------------------------------------------------------------------------
// akf_pkg
// shared constants, operation codes, microprogram and types of the
// altitude kalman filter
// ----------------------------------------------------------------------------
package akf_pkg;

    localparam int DEF_WORD_BITS = 48;
    localparam int DEF_FRAC_BITS = 24;

    // port field widths
    localparam int ALT_W     = 48;
    localparam int ACC_W     = 36;
    localparam int DT_W      = 25;
    localparam int EST_W     = 48;
    localparam int S_DATA_W  = 112;
    localparam int S_USER_W  = 2;
    localparam int M_DATA_W  = 96;
    localparam int CFG_W     = 47;
    localparam int APB_W     = 64;
    localparam int APB_AW    = 5;

    // register indexes
    localparam logic [1:0] CFG_MEAS_NOISE = 2'd0;
    localparam logic [1:0] CFG_PROC_POS   = 2'd1;
    localparam logic [1:0] CFG_PROC_VEL   = 2'd2;
    localparam logic [1:0] CFG_PROC_BIAS  = 2'd3;

    localparam logic [CFG_W-1:0] RST_MEAS_NOISE = 47'd33554432;
    localparam logic [CFG_W-1:0] RST_PROC_POS   = 47'd16777;
    localparam logic [CFG_W-1:0] RST_PROC_VEL   = 47'd1678;
    localparam logic [CFG_W-1:0] RST_PROC_BIAS  = 47'd16777;

    // commands
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_INIT = 1'b1;

    // alu operations
    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_HALF = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;

    // register file and operand codes
    localparam int RF_DEPTH = 64;
    localparam int RF_AW    = 6;
    localparam int OPD_W    = 7;
    localparam int PC_W     = 7;

    localparam logic [OPD_W-1:0] A_POS   = 7'd0;
    localparam logic [OPD_W-1:0] A_VEL   = 7'd1;
    localparam logic [OPD_W-1:0] A_BIAS  = 7'd2;
    localparam logic [OPD_W-1:0] A_P     = 7'd3;
    localparam logic [OPD_W-1:0] A_H     = 7'd12;
    localparam logic [OPD_W-1:0] A_NP    = 7'd13;
    localparam logic [OPD_W-1:0] A_NV    = 7'd14;
    localparam logic [OPD_W-1:0] A_T     = 7'd15;
    localparam logic [OPD_W-1:0] A_AP    = 7'd16;
    localparam logic [OPD_W-1:0] A_PK    = 7'd25;
    localparam logic [OPD_W-1:0] A_DEN   = 7'd34;
    localparam logic [OPD_W-1:0] A_K     = 7'd35;
    localparam logic [OPD_W-1:0] A_INNOV = 7'd38;

    localparam logic [OPD_W-1:0] S_ALT  = 7'd64;
    localparam logic [OPD_W-1:0] S_ACC  = 7'd65;
    localparam logic [OPD_W-1:0] S_DT   = 7'd66;
    localparam logic [OPD_W-1:0] S_R    = 7'd67;
    localparam logic [OPD_W-1:0] S_QP   = 7'd68;
    localparam logic [OPD_W-1:0] S_QV   = 7'd69;
    localparam logic [OPD_W-1:0] S_QB   = 7'd70;
    localparam logic [OPD_W-1:0] S_ZERO = 7'd71;

    localparam logic [PC_W-1:0] PC_TICK = 7'd0;
    localparam logic [PC_W-1:0] PC_FORK = 7'd11;
    localparam logic [PC_W-1:0] PC_MEAS = 7'd14;
    localparam logic [PC_W-1:0] PC_INIT = 7'd85;

    typedef struct packed {
        logic [2:0]       op;
        logic [OPD_W-1:0] a;
        logic [OPD_W-1:0] b;
        logic [OPD_W-1:0] d;
        logic             last;
    } instr_t;

    typedef struct packed {
        logic       start;
        logic [2:0] op;
    } alu_req_t;

    function automatic instr_t mk(input logic [2:0] op, input logic [OPD_W-1:0] a,
                                  input logic [OPD_W-1:0] b, input logic [OPD_W-1:0] d,
                                  input logic last);
        instr_t r;
        r.op   = op;
        r.a    = a;
        r.b    = b;
        r.d    = d;
        r.last = last;
        return r;
    endfunction

    function automatic instr_t prog_rom(input logic [PC_W-1:0] pc);
        instr_t r;
        unique case (pc)
            // propagation
            7'd0:  r = mk(OP_MUL,  S_DT,   S_DT,   A_T,  1'b0);
            7'd1:  r = mk(OP_HALF, A_T,    S_ZERO, A_H,  1'b0);
            7'd2:  r = mk(OP_MUL,  A_VEL,  S_DT,   A_T,  1'b0);
            7'd3:  r = mk(OP_ADD,  A_POS,  A_T,    A_NP, 1'b0);
            7'd4:  r = mk(OP_MUL,  A_BIAS, A_H,    A_T,  1'b0);
            7'd5:  r = mk(OP_ADD,  A_NP,   A_T,    A_NP, 1'b0);
            7'd6:  r = mk(OP_MUL,  S_ACC,  A_H,    A_T,  1'b0);
            7'd7:  r = mk(OP_ADD,  A_NP,   A_T,    A_NP, 1'b0);
            7'd8:  r = mk(OP_MUL,  A_BIAS, S_DT,   A_T,  1'b0);
            7'd9:  r = mk(OP_ADD,  A_VEL,  A_T,    A_NV, 1'b0);
            7'd10: r = mk(OP_MUL,  S_ACC,  S_DT,   A_T,  1'b0);
            7'd11: r = mk(OP_ADD,  A_NV,   A_T,    A_NV, 1'b0);
            // no sample
            7'd12: r = mk(OP_ADD,  A_NP,   S_ZERO, A_POS, 1'b0);
            7'd13: r = mk(OP_ADD,  A_NV,   S_ZERO, A_VEL, 1'b1);
            // a*p, row 0
            7'd14: r = mk(OP_MUL,  S_DT,   A_P+7'd3, A_T,    1'b0);
            7'd15: r = mk(OP_ADD,  A_P,    A_T,      A_AP,   1'b0);
            7'd16: r = mk(OP_MUL,  A_H,    A_P+7'd6, A_T,    1'b0);
            7'd17: r = mk(OP_ADD,  A_AP,   A_T,      A_AP,   1'b0);
            7'd18: r = mk(OP_MUL,  S_DT,   A_P+7'd4, A_T,    1'b0);
            7'd19: r = mk(OP_ADD,  A_P+7'd1, A_T,    A_AP+7'd1, 1'b0);
            7'd20: r = mk(OP_MUL,  A_H,    A_P+7'd7, A_T,    1'b0);
            7'd21: r = mk(OP_ADD,  A_AP+7'd1, A_T,   A_AP+7'd1, 1'b0);
            7'd22: r = mk(OP_MUL,  S_DT,   A_P+7'd5, A_T,    1'b0);
            7'd23: r = mk(OP_ADD,  A_P+7'd2, A_T,    A_AP+7'd2, 1'b0);
            7'd24: r = mk(OP_MUL,  A_H,    A_P+7'd8, A_T,    1'b0);
            7'd25: r = mk(OP_ADD,  A_AP+7'd2, A_T,   A_AP+7'd2, 1'b0);
            // a*p, row 1
            7'd26: r = mk(OP_MUL,  S_DT,   A_P+7'd6, A_T,    1'b0);
            7'd27: r = mk(OP_ADD,  A_P+7'd3, A_T,    A_AP+7'd3, 1'b0);
            7'd28: r = mk(OP_MUL,  S_DT,   A_P+7'd7, A_T,    1'b0);
            7'd29: r = mk(OP_ADD,  A_P+7'd4, A_T,    A_AP+7'd4, 1'b0);
            7'd30: r = mk(OP_MUL,  S_DT,   A_P+7'd8, A_T,    1'b0);
            7'd31: r = mk(OP_ADD,  A_P+7'd5, A_T,    A_AP+7'd5, 1'b0);
            // (a*p)*a^t, row 0
            7'd32: r = mk(OP_MUL,  A_AP+7'd1, S_DT,  A_T,    1'b0);
            7'd33: r = mk(OP_ADD,  A_AP,      A_T,   A_PK,   1'b0);
            7'd34: r = mk(OP_MUL,  A_AP+7'd2, A_H,   A_T,    1'b0);
            7'd35: r = mk(OP_ADD,  A_PK,      A_T,   A_PK,   1'b0);
            7'd36: r = mk(OP_MUL,  A_AP+7'd2, S_DT,  A_T,    1'b0);
            7'd37: r = mk(OP_ADD,  A_AP+7'd1, A_T,   A_PK+7'd1, 1'b0);
            7'd38: r = mk(OP_ADD,  A_AP+7'd2, S_ZERO, A_PK+7'd2, 1'b0);
            // row 1
            7'd39: r = mk(OP_MUL,  A_AP+7'd4, S_DT,  A_T,    1'b0);
            7'd40: r = mk(OP_ADD,  A_AP+7'd3, A_T,   A_PK+7'd3, 1'b0);
            7'd41: r = mk(OP_MUL,  A_AP+7'd5, A_H,   A_T,    1'b0);
            7'd42: r = mk(OP_ADD,  A_PK+7'd3, A_T,   A_PK+7'd3, 1'b0);
            7'd43: r = mk(OP_MUL,  A_AP+7'd5, S_DT,  A_T,    1'b0);
            7'd44: r = mk(OP_ADD,  A_AP+7'd4, A_T,   A_PK+7'd4, 1'b0);
            7'd45: r = mk(OP_ADD,  A_AP+7'd5, S_ZERO, A_PK+7'd5, 1'b0);
            // row 2, taken straight from the bottom row of p
            7'd46: r = mk(OP_MUL,  A_P+7'd7,  S_DT,  A_T,    1'b0);
            7'd47: r = mk(OP_ADD,  A_P+7'd6,  A_T,   A_PK+7'd6, 1'b0);
            7'd48: r = mk(OP_MUL,  A_P+7'd8,  A_H,   A_T,    1'b0);
            7'd49: r = mk(OP_ADD,  A_PK+7'd6, A_T,   A_PK+7'd6, 1'b0);
            7'd50: r = mk(OP_MUL,  A_P+7'd8,  S_DT,  A_T,    1'b0);
            7'd51: r = mk(OP_ADD,  A_P+7'd7,  A_T,   A_PK+7'd7, 1'b0);
            7'd52: r = mk(OP_ADD,  A_P+7'd8,  S_ZERO, A_PK+7'd8, 1'b0);
            // process noise, gain
            7'd53: r = mk(OP_ADD,  A_PK,      S_QP,  A_PK,      1'b0);
            7'd54: r = mk(OP_ADD,  A_PK+7'd4, S_QV,  A_PK+7'd4, 1'b0);
            7'd55: r = mk(OP_ADD,  A_PK+7'd8, S_QB,  A_PK+7'd8, 1'b0);
            7'd56: r = mk(OP_ADD,  A_PK,      S_R,   A_DEN,     1'b0);
            7'd57: r = mk(OP_DIV,  A_PK,      A_DEN, A_K,       1'b0);
            7'd58: r = mk(OP_DIV,  A_PK+7'd3, A_DEN, A_K+7'd1,  1'b0);
            7'd59: r = mk(OP_DIV,  A_PK+7'd6, A_DEN, A_K+7'd2,  1'b0);
            // state correction
            7'd60: r = mk(OP_SUB,  S_ALT,    A_NP,    A_INNOV, 1'b0);
            7'd61: r = mk(OP_MUL,  A_K,      A_INNOV, A_T,     1'b0);
            7'd62: r = mk(OP_ADD,  A_NP,     A_T,     A_POS,   1'b0);
            7'd63: r = mk(OP_MUL,  A_K+7'd1, A_INNOV, A_T,     1'b0);
            7'd64: r = mk(OP_ADD,  A_NV,     A_T,     A_VEL,   1'b0);
            7'd65: r = mk(OP_MUL,  A_K+7'd2, A_INNOV, A_T,     1'b0);
            7'd66: r = mk(OP_ADD,  A_BIAS,   A_T,     A_BIAS,  1'b0);
            // covariance correction
            7'd67: r = mk(OP_MUL,  A_K,       A_PK,      A_T,      1'b0);
            7'd68: r = mk(OP_SUB,  A_PK,      A_T,       A_P,      1'b0);
            7'd69: r = mk(OP_MUL,  A_K,       A_PK+7'd1, A_T,      1'b0);
            7'd70: r = mk(OP_SUB,  A_PK+7'd1, A_T,       A_P+7'd1, 1'b0);
            7'd71: r = mk(OP_MUL,  A_K,       A_PK+7'd2, A_T,      1'b0);
            7'd72: r = mk(OP_SUB,  A_PK+7'd2, A_T,       A_P+7'd2, 1'b0);
            7'd73: r = mk(OP_MUL,  A_K+7'd1,  A_PK,      A_T,      1'b0);
            7'd74: r = mk(OP_SUB,  A_PK+7'd3, A_T,       A_P+7'd3, 1'b0);
            7'd75: r = mk(OP_MUL,  A_K+7'd1,  A_PK+7'd1, A_T,      1'b0);
            7'd76: r = mk(OP_SUB,  A_PK+7'd4, A_T,       A_P+7'd4, 1'b0);
            7'd77: r = mk(OP_MUL,  A_K+7'd1,  A_PK+7'd2, A_T,      1'b0);
            7'd78: r = mk(OP_SUB,  A_PK+7'd5, A_T,       A_P+7'd5, 1'b0);
            7'd79: r = mk(OP_MUL,  A_K+7'd2,  A_PK,      A_T,      1'b0);
            7'd80: r = mk(OP_SUB,  A_PK+7'd6, A_T,       A_P+7'd6, 1'b0);
            7'd81: r = mk(OP_MUL,  A_K+7'd2,  A_PK+7'd1, A_T,      1'b0);
            7'd82: r = mk(OP_SUB,  A_PK+7'd7, A_T,       A_P+7'd7, 1'b0);
            7'd83: r = mk(OP_MUL,  A_K+7'd2,  A_PK+7'd2, A_T,      1'b0);
            7'd84: r = mk(OP_SUB,  A_PK+7'd8, A_T,       A_P+7'd8, 1'b1);
            // init command
            7'd85: r = mk(OP_ADD,  S_ALT,  S_ZERO, A_POS,  1'b0);
            7'd86: r = mk(OP_ADD,  S_ZERO, S_ZERO, A_VEL,  1'b0);
            7'd87: r = mk(OP_ADD,  S_ZERO, S_ZERO, A_BIAS, 1'b1);
            default: r = mk(OP_ADD, S_ZERO, S_ZERO, A_T, 1'b1);
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/akf_alu.sv */
// ----------------------------------------------------------------------------
// akf_alu
// shared saturating unit: registered add, subtract and halve, bit-serial
// multiply and restoring divide in fixed point
// ----------------------------------------------------------------------------
module akf_alu #(
    parameter int W = akf_pkg::DEF_WORD_BITS,
    parameter int F = akf_pkg::DEF_FRAC_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  akf_pkg::alu_req_t  req,
    input  logic signed [W-1:0] opa,
    input  logic signed [W-1:0] opb,
    output logic               done,
    output logic signed [W-1:0] result
);
    import akf_pkg::*;

    localparam int LW = W + F;
    localparam int CW = $clog2(LW + 1);
    localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [2:0]    op_reg;
    logic          neg_reg;
    logic [W-1:0]  mc_reg;
    logic [W-1:0]  hi_reg;
    logic [LW-1:0] lo_reg;
    logic [W-1:0]  res_reg;

    logic [W-1:0]  mag_a, mag_b;
    logic [W:0]    add_s, sub_s, half_s;
    logic [W-1:0]  add_res, sub_res;
    logic [W:0]    msum, trial;
    logic          dge;
    logic [W:0]    tdiff;
    logic [2*W-1:0] prod;
    logic          fin_ovf;
    logic [W-2:0]  fin_m;
    logic [W-1:0]  fin_res;

    assign mag_a = opa[W-1] ? (~opa + 1'b1) : opa;
    assign mag_b = opb[W-1] ? (~opb + 1'b1) : opb;

    assign add_s  = {opa[W-1], opa} + {opb[W-1], opb};
    assign sub_s  = {opa[W-1], opa} - {opb[W-1], opb};
    assign half_s = {opa[W-1], opa} + {{W{1'b0}}, opa[W-1]};

    assign add_res = (add_s[W] != add_s[W-1]) ? (add_s[W] ? SMIN : SMAX) : add_s[W-1:0];
    assign sub_res = (sub_s[W] != sub_s[W-1]) ? (sub_s[W] ? SMIN : SMAX) : sub_s[W-1:0];

    assign msum  = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mc_reg} : {(W+1){1'b0}});
    assign trial = {hi_reg, lo_reg[LW-1]};
    assign dge   = trial >= {1'b0, mc_reg};
    assign tdiff = trial - {1'b0, mc_reg};

    assign prod = {hi_reg, lo_reg[LW-1 -: W]};

    always_comb begin
        if (op_reg == OP_MUL) begin
            fin_ovf = |prod[2*W-1:F+W-1];
            fin_m   = prod[F +: W-1];
        end else begin
            fin_ovf = |lo_reg[LW-1:W-1];
            fin_m   = lo_reg[W-2:0];
        end
        if (fin_ovf) begin
            fin_res = neg_reg ? SMIN : SMAX;
        end else if (neg_reg) begin
            fin_res = ~{1'b0, fin_m} + 1'b1;
        end else begin
            fin_res = {1'b0, fin_m};
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                if (req.op == OP_MUL) begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= CW'(W);
                end else if (req.op == OP_DIV && mag_b != '0) begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= CW'(LW);
                end else begin
                    done_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (req.start) begin
            op_reg  <= req.op;
            neg_reg <= opa[W-1] ^ opb[W-1];
            hi_reg  <= '0;
            unique case (req.op)
                OP_ADD:  res_reg <= add_res;
                OP_SUB:  res_reg <= sub_res;
                OP_HALF: res_reg <= half_s[W:1];
                OP_MUL: begin
                    mc_reg <= mag_a;
                    lo_reg <= {{F{1'b0}}, mag_b};
                end
                OP_DIV: begin
                    mc_reg  <= mag_b;
                    lo_reg  <= {mag_a, {F{1'b0}}};
                    res_reg <= '0;
                end
                default: res_reg <= '0;
            endcase
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                res_reg <= fin_res;
            end else if (op_reg == OP_MUL) begin
                hi_reg <= msum[W:1];
                lo_reg <= {msum[0], lo_reg[LW-1:1]};
            end else begin
                hi_reg <= dge ? tdiff[W-1:0] : trial[W-1:0];
                lo_reg <= {lo_reg[LW-2:0], dge};
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

/* rtl/core/akf_regfile.sv */
// ----------------------------------------------------------------------------
// akf_regfile
// working memory of state, covariance and temporaries, two registered read
// ports, one write port, valid bits giving the reset values
// ----------------------------------------------------------------------------
module akf_regfile #(
    parameter int W = akf_pkg::DEF_WORD_BITS,
    parameter int F = akf_pkg::DEF_FRAC_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [akf_pkg::RF_AW-1:0] rd_addr_a,
    input  logic [akf_pkg::RF_AW-1:0] rd_addr_b,
    input  logic                      wr_en,
    input  logic [akf_pkg::RF_AW-1:0] wr_addr,
    input  logic signed [W-1:0]       wr_data,
    output logic signed [W-1:0]       rd_data_a,
    output logic signed [W-1:0]       rd_data_b
);
    import akf_pkg::*;

    localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] ONE  = (F >= W - 1) ? SMAX : (W'(1) << F);

    logic [W-1:0]        mem [RF_DEPTH];
    logic [RF_DEPTH-1:0] valid_reg;
    logic [W-1:0]        qa_reg, qb_reg;
    logic                va_reg, vb_reg;
    logic [RF_AW-1:0]    aa_reg, ab_reg;

    function automatic logic [W-1:0] rst_val(input logic [RF_AW-1:0] a);
        logic [W-1:0] v;
        if (a == A_P[RF_AW-1:0] || a == RF_AW'(A_P + 7'd4) || a == RF_AW'(A_P + 7'd8)) begin
            v = ONE;
        end else begin
            v = '0;
        end
        return v;
    endfunction

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        qa_reg <= mem[rd_addr_a];
        qb_reg <= mem[rd_addr_b];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        va_reg <= valid_reg[rd_addr_a];
        vb_reg <= valid_reg[rd_addr_b];
        aa_reg <= rd_addr_a;
        ab_reg <= rd_addr_b;
    end

    assign rd_data_a = va_reg ? qa_reg : rst_val(aa_reg);
    assign rd_data_b = vb_reg ? qb_reg : rst_val(ab_reg);

endmodule

/* rtl/core/altitude_kalman_filter_unit.sv */
// ----------------------------------------------------------------------------
// altitude_kalman_filter_unit
// three-state altitude kalman filter, fixed point, one shared alu run by a
// microprogram sequencer
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  s_*       in         tuser: cmd, new_measurement; tdata: alt, accel, dt
//  m_*       out        tdata: altitude, velocity estimates
//  p*        in/out     apb registers r, q_pos, q_vel, q_bias at 8*i
//
//  one word at a time; s_tready is high only between items
//  every step passes through the read, execute and wait states; a multiply or
//  divide waits there on the bit-serial alu, unless the divisor is zero
//  tick without sample: 6 multiplies, 8 adds; with sample: 36 multiplies,
//  3 divides, 44 adds; init: 3 adds; the done state then posts the result
//  the result stays in the output register until taken; a stalled m side
//  holds the next result back at the end of its item
//  reset is synchronous, covariance comes up as identity with no sweep
// ----------------------------------------------------------------------------
module altitude_kalman_filter_unit #(
    parameter int WORD_BITS = akf_pkg::DEF_WORD_BITS,
    parameter int FRAC_BITS = akf_pkg::DEF_FRAC_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [akf_pkg::S_DATA_W-1:0] s_tdata,  // alt[47:0] accel[83:48] dt[108:84]
    input  logic [akf_pkg::S_USER_W-1:0] s_tuser,  // cmd[0] new_measurement[1]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [akf_pkg::M_DATA_W-1:0] m_tdata,  // altitude[47:0] velocity[95:48]
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [akf_pkg::APB_AW-1:0]   paddr,
    input  logic [akf_pkg::APB_W-1:0]    pwdata,
    output logic [akf_pkg::APB_W-1:0]    prdata,
    output logic                         pready
);
    import akf_pkg::*;

    localparam int W = WORD_BITS;
    localparam logic signed [63:0] WMAX = (64'sd1 <<< (W - 1)) - 64'sd1;
    localparam logic signed [63:0] WMIN = -WMAX - 64'sd1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_EX   = 3'd2;
    localparam logic [2:0] ST_WT   = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]      state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            meas_reg;
    logic [W-1:0]    alt_reg, acc_reg, dt_reg;
    logic [CFG_W-1:0] r_reg, qp_reg, qv_reg, qb_reg;
    logic            out_valid_reg;
    logic [W-1:0]    pos_out_reg, vel_out_reg;
    logic [W-1:0]    pos_sh_reg, vel_sh_reg;

    instr_t          instr;
    alu_req_t        alu_req;
    logic            alu_done;
    logic [W-1:0]    alu_res;
    logic [W-1:0]    rf_a, rf_b, opa, opb;
    logic            wr_en;
    logic            accept;
    logic            cfg_wr;
    logic            out_load;

    function automatic logic [W-1:0] sat_w(input logic signed [63:0] v);
        logic signed [63:0] c;
        if (v > WMAX) begin
            c = WMAX;
        end else if (v < WMIN) begin
            c = WMIN;
        end else begin
            c = v;
        end
        return c[W-1:0];
    endfunction

    function automatic logic [EST_W-1:0] to_est(input logic [W-1:0] v);
        logic signed [63:0] e;
        e = 64'(signed'(v));
        return e[EST_W-1:0];
    endfunction

    assign instr    = prog_rom(pc_reg);
    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign wr_en    = (state_reg == ST_WT) && alu_done;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    // sequencer
    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_RD;
                    pc_next    = (s_tuser[0] == CMD_INIT) ? PC_INIT : PC_TICK;
                end
            end
            ST_RD: state_next = ST_EX;
            ST_EX: state_next = ST_WT;
            ST_WT: begin
                if (alu_done) begin
                    if (instr.last) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_RD;
                        if (pc_reg == PC_FORK) begin
                            pc_next = meas_reg ? PC_MEAS : PC_FORK + 1'b1;
                        end else begin
                            pc_next = pc_reg + 1'b1;
                        end
                    end
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    // input word
    always_ff @(posedge aclk) begin
        if (accept) begin
            meas_reg <= s_tuser[1];
            alt_reg  <= sat_w(64'(signed'(s_tdata[ALT_W-1:0])));
            acc_reg  <= sat_w(64'(signed'(s_tdata[ALT_W +: ACC_W])));
            dt_reg   <= sat_w(64'(s_tdata[ALT_W+ACC_W +: DT_W]));
        end
    end

    // operand select
    always_comb begin
        case (instr.a)
            S_ALT:   opa = alt_reg;
            S_ACC:   opa = acc_reg;
            S_DT:    opa = dt_reg;
            S_R:     opa = sat_w(64'(r_reg));
            S_QP:    opa = sat_w(64'(qp_reg));
            S_QV:    opa = sat_w(64'(qv_reg));
            S_QB:    opa = sat_w(64'(qb_reg));
            S_ZERO:  opa = '0;
            default: opa = rf_a;
        endcase
        case (instr.b)
            S_ALT:   opb = alt_reg;
            S_ACC:   opb = acc_reg;
            S_DT:    opb = dt_reg;
            S_R:     opb = sat_w(64'(r_reg));
            S_QP:    opb = sat_w(64'(qp_reg));
            S_QV:    opb = sat_w(64'(qv_reg));
            S_QB:    opb = sat_w(64'(qb_reg));
            S_ZERO:  opb = '0;
            default: opb = rf_b;
        endcase
    end

    assign alu_req.start = (state_reg == ST_EX);
    assign alu_req.op    = instr.op;

    akf_alu #(
        .W (WORD_BITS),
        .F (FRAC_BITS)
    ) u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .opa     (opa),
        .opb     (opb),
        .done    (alu_done),
        .result  (alu_res)
    );

    akf_regfile #(
        .W (WORD_BITS),
        .F (FRAC_BITS)
    ) u_rf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_addr_a (instr.a[RF_AW-1:0]),
        .rd_addr_b (instr.b[RF_AW-1:0]),
        .wr_en     (wr_en),
        .wr_addr   (instr.d[RF_AW-1:0]),
        .wr_data   (alu_res),
        .rd_data_a (rf_a),
        .rd_data_b (rf_b)
    );

    // copies of position and velocity for the result word
    always_ff @(posedge aclk) begin
        if (wr_en && instr.d == A_POS) begin
            pos_sh_reg <= alu_res;
        end
        if (wr_en && instr.d == A_VEL) begin
            vel_sh_reg <= alu_res;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            pos_out_reg <= pos_sh_reg;
            vel_out_reg <= vel_sh_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {to_est(vel_out_reg), to_est(pos_out_reg)};

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_reg  <= RST_MEAS_NOISE;
            qp_reg <= RST_PROC_POS;
            qv_reg <= RST_PROC_VEL;
            qb_reg <= RST_PROC_BIAS;
        end else if (cfg_wr) begin
            unique case (paddr[APB_AW-1:3])
                CFG_MEAS_NOISE: r_reg  <= pwdata[CFG_W-1:0];
                CFG_PROC_POS:   qp_reg <= pwdata[CFG_W-1:0];
                CFG_PROC_VEL:   qv_reg <= pwdata[CFG_W-1:0];
                CFG_PROC_BIAS:  qb_reg <= pwdata[CFG_W-1:0];
                default:        r_reg  <= r_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[APB_AW-1:3])
            CFG_MEAS_NOISE: prdata = APB_W'(r_reg);
            CFG_PROC_POS:   prdata = APB_W'(qp_reg);
            CFG_PROC_VEL:   prdata = APB_W'(qv_reg);
            CFG_PROC_BIAS:  prdata = APB_W'(qb_reg);
            default:        prdata = '0;
        endcase
    end

endmodule

/* rtl/core/akf_checker.sv */
// ----------------------------------------------------------------------------
// akf_checker
// port-level checks of the altitude kalman filter unit
// ----------------------------------------------------------------------------
module akf_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [akf_pkg::M_DATA_W-1:0] m_tdata,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic [akf_pkg::APB_AW-1:0]   paddr,
    input logic [akf_pkg::APB_W-1:0]    pwdata,
    input logic [akf_pkg::APB_W-1:0]    prdata,
    input logic                         pready
);
    import akf_pkg::*;

    // busy right after taking a word
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while busy");

    // a new result only shows after a busy stretch
    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without work");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped or changed under stall");

    // register read back
    a_cfg_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && pready) |=>
            ($stable(paddr) |-> prdata[CFG_W-1:0] == $past(pwdata[CFG_W-1:0])))
        else $error("register read back mismatch");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind altitude_kalman_filter_unit akf_checker u_akf_checker (.*);
